FILE: design/midi_stream_to_smf_event_encoder_core_defines.svh
// assertion macros shared by the encoder modules
`ifndef MIDI_STREAM_TO_SMF_EVENT_ENCODER_CORE_DEFINES_SVH
`define MIDI_STREAM_TO_SMF_EVENT_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define MSSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/msse_pkg.sv
// shared types and constants for the midi to track event encoder
package msse_pkg;

   localparam int TIME_BITS  = 32;
   localparam int DELTA_BITS = 28;
   localparam int DIFF_BITS  = (TIME_BITS > DELTA_BITS) ? TIME_BITS : DELTA_BITS;
   localparam int EVT_BYTES  = 7;

   localparam logic [DIFF_BITS-1:0] DELTA_MAX = DIFF_BITS'((64'd1 << DELTA_BITS) - 64'd1);

   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_CONTROL  = 4'hB;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;
   localparam logic [3:0] NIB_SYSTEM   = 4'hF;
   localparam logic [7:0] SYSEX_START  = 8'hF0;

   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_CONTROL  = 8'hB0;

   localparam logic [6:0] GROUP_MASK = 7'h7F;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_DATA1 = 3'd1,
      PH_DATA2 = 3'd2,
      PH_SKIP  = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NOTE_OFF = 2'd0,
      KIND_NOTE_ON  = 2'd1,
      KIND_CONTROL  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [EVT_BYTES-1:0][7:0] data;
      logic [2:0]                count;
   } evt_type;

endpackage

FILE: design/msse_if.sv
// valid/ready channel interfaces for midi input and track byte output
interface msse_req_if
   import msse_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [7:0]           midi_byte;
   logic [TIME_BITS-1:0] time_ms;

   modport source (output valid, output midi_byte, output time_ms, input ready);
   modport sink (input valid, input midi_byte, input time_ms, output ready);
endinterface

interface msse_rsp_if
   import msse_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       last_of_event;

   modport source (output valid, output track_byte, output last_of_event, input ready);
   modport sink (input valid, input track_byte, input last_of_event, output ready);
endinterface

FILE: design/msse_parser.sv
// input register, midi status parser and track event builder
`include "midi_stream_to_smf_event_encoder_core_defines.svh"

module msse_parser
   import msse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   msse_req_if.sink   req,
   input  logic       ser_ready,
   output logic       evt_valid,
   output evt_type    evt
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [TIME_BITS-1:0] in_time_ff;
   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           first_ff, first_in;
   logic [TIME_BITS-1:0] event_time_ff, event_time_in;
   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in;

   logic                 consume;
   logic                 req_xfer;
   logic [DIFF_BITS-1:0] diff;
   logic [DELTA_BITS-1:0] delta;
   logic [6:0]           g3, g2, g1, g0;
   logic [7:0]           status;

   assign consume   = in_valid_ff && ((phase_ff != PH_DATA2) || ser_ready);
   assign req.ready = !in_valid_ff || consume;
   assign req_xfer  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_xfer) begin
         in_byte_ff <= req.midi_byte;
         in_time_ff <= req.time_ms;
      end
   end

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (consume) begin
         case (phase_ff)
            PH_DATA1: phase_in = PH_DATA2;
            PH_DATA2: phase_in = PH_IDLE;
            PH_SKIP:  phase_in = PH_IDLE;
            default: begin
               phase_in = PH_IDLE;
               if (in_byte_ff[7]) begin
                  case (in_byte_ff[7:4])
                     NIB_NOTE_OFF: phase_in = PH_DATA1;
                     NIB_NOTE_ON:  phase_in = PH_DATA1;
                     NIB_CONTROL:  phase_in = PH_DATA1;
                     NIB_PROGRAM:  phase_in = PH_SKIP;
                     NIB_SYSTEM:   phase_in = (in_byte_ff == SYSEX_START) ? PH_SKIP : PH_IDLE;
                     default:      phase_in = PH_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   // delta time since the previous emitted event
   always_comb begin
      diff = '0;
      if (event_time_ff >= prev_time_ff) begin
         diff = DIFF_BITS'(event_time_ff - prev_time_ff);
      end
      delta = (diff > DELTA_MAX) ? DELTA_MAX[DELTA_BITS-1:0] : diff[DELTA_BITS-1:0];
      g3 = delta[27:21] & GROUP_MASK;
      g2 = delta[20:14] & GROUP_MASK;
      g1 = delta[13:7]  & GROUP_MASK;
      g0 = delta[6:0]   & GROUP_MASK;
   end

   // parser outputs and event assembly
   always_comb begin
      kind_in       = kind_ff;
      first_in      = first_ff;
      event_time_in = event_time_ff;
      prev_time_in  = prev_time_ff;
      evt_valid     = 1'b0;

      case (kind_ff)
         KIND_NOTE_OFF: status = STATUS_NOTE_OFF;
         KIND_NOTE_ON:  status = STATUS_NOTE_ON;
         default:       status = STATUS_CONTROL;
      endcase

      evt.data = '0;
      if (g3 != 7'd0) begin
         evt.count   = 3'd7;
         evt.data[0] = {1'b1, g3};
         evt.data[1] = {1'b1, g2};
         evt.data[2] = {1'b1, g1};
         evt.data[3] = {1'b0, g0};
         evt.data[4] = status;
         evt.data[5] = first_ff;
         evt.data[6] = in_byte_ff;
      end else if (g2 != 7'd0) begin
         evt.count   = 3'd6;
         evt.data[0] = {1'b1, g2};
         evt.data[1] = {1'b1, g1};
         evt.data[2] = {1'b0, g0};
         evt.data[3] = status;
         evt.data[4] = first_ff;
         evt.data[5] = in_byte_ff;
      end else if (g1 != 7'd0) begin
         evt.count   = 3'd5;
         evt.data[0] = {1'b1, g1};
         evt.data[1] = {1'b0, g0};
         evt.data[2] = status;
         evt.data[3] = first_ff;
         evt.data[4] = in_byte_ff;
      end else begin
         evt.count   = 3'd4;
         evt.data[0] = {1'b0, g0};
         evt.data[1] = status;
         evt.data[2] = first_ff;
         evt.data[3] = in_byte_ff;
      end

      if (consume) begin
         case (phase_ff)
            PH_DATA1: first_in = in_byte_ff;
            PH_DATA2: begin
               evt_valid    = 1'b1;
               prev_time_in = event_time_ff;
            end
            PH_SKIP: begin
            end
            default: begin
               if (in_byte_ff[7]) begin
                  event_time_in = in_time_ff;
                  case (in_byte_ff[7:4])
                     NIB_NOTE_OFF: kind_in = KIND_NOTE_OFF;
                     NIB_NOTE_ON:  kind_in = KIND_NOTE_ON;
                     NIB_CONTROL:  kind_in = KIND_CONTROL;
                     default:      kind_in = kind_ff;
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         kind_ff       <= KIND_NOTE_OFF;
         first_ff      <= '0;
         event_time_ff <= '0;
         prev_time_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         first_ff      <= first_in;
         event_time_ff <= event_time_in;
         prev_time_ff  <= prev_time_in;
      end
   end

   `MSSE_ASSERT_NOW(a_evt_only_on_second_data, evt_valid, phase_ff == PH_DATA2 && ser_ready, "event offered outside second data byte")
   `MSSE_ASSERT_NEXT(a_event_resets_phase, evt_valid, phase_ff == PH_IDLE, "parser not idle after event")
   `MSSE_ASSERT_NEXT(a_prev_time_tracks, evt_valid, prev_time_ff == $past(event_time_ff), "previous time not updated")

endmodule

FILE: design/msse_serializer.sv
// event buffer that hands track bytes out one transfer at a time
`include "midi_stream_to_smf_event_encoder_core_defines.svh"

module msse_serializer
   import msse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       evt_valid,
   input  evt_type    evt,
   output logic       ser_ready,
   msse_rsp_if.source rsp
);

   logic                      busy_ff, busy_in;
   logic [2:0]                idx_ff, idx_in;
   logic [2:0]                count_ff;
   logic [EVT_BYTES-1:0][7:0] data_ff;
   logic                      last;
   logic                      rsp_xfer;
   logic                      load;

   assign last              = idx_ff == 3'(count_ff - 3'd1);
   assign rsp_xfer          = rsp.valid && rsp.ready;
   assign ser_ready         = !busy_ff || (rsp_xfer && last);
   assign load              = evt_valid && ser_ready;
   assign rsp.valid         = busy_ff;
   assign rsp.track_byte    = data_ff[idx_ff];
   assign rsp.last_of_event = last;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_xfer) begin
         if (last) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = 3'(idx_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      if (load) begin
         data_ff  <= evt.data;
         count_ff <= evt.count;
      end
   end

   `MSSE_ASSERT_NOW(a_load_count_range, load, evt.count >= 3'd4 && evt.count <= 3'd7, "event length out of range")
   `MSSE_ASSERT_NEXT(a_stall_holds_index, busy_ff && !rsp.ready, $stable(idx_ff) && busy_ff, "index moved under stall")
   `MSSE_ASSERT_NEXT(a_last_frees_buffer, rsp_xfer && last && !load, !busy_ff, "buffer busy after last transfer")
   `MSSE_ASSERT_NOW(a_index_in_event, busy_ff, idx_ff < count_ff, "index past end of event")

endmodule

FILE: design/midi_stream_to_smf_event_encoder_core.sv
// top level: midi byte stream in, standard midi file track event bytes out
// an event's first byte is valid once the event is loaded into the output buffer
// one input transfer per cycle unless an event waits for the buffer, which holds 4 to 7 bytes
// the output buffer gives one track byte per cycle while rsp ready is high, which sets the event rate
// input items that emit nothing pass at one per cycle, also while an event drains
// reset is synchronous, active high, and returns the parser to idle with zeroed time stamps
module midi_stream_to_smf_event_encoder_core
   import msse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   msse_req_if.sink   req_ch,
   msse_rsp_if.source rsp_ch
);

   logic    evt_valid;
   evt_type evt;
   logic    ser_ready;

   msse_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .ser_ready (ser_ready),
      .evt_valid (evt_valid),
      .evt       (evt)
   );

   msse_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt       (evt),
      .ser_ready (ser_ready),
      .rsp       (rsp_ch)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench for the midi to track event encoder: typed-in table, then bursty random traffic
module testbench;
   import msse_pkg::*;

   typedef struct packed {
      logic [7:0]           midi;
      logic [TIME_BITS-1:0] stamp;
      logic [2:0]           n_typed;
      logic [0:6][7:0]      typed;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       last_of_event;
   } track_entry_type;

   localparam int RANDOM_ITEMS = 288;
   localparam int HOLD_CYCLES  = 80;

   localparam logic [3:0] NIB_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] NIB_PITCH_BEND    = 4'hE;

   // n_typed of zero: checked against the encoder model only
   localparam dir_row_type DIR_TABLE [26] = '{
      '{8'h90, 32'd5,          3'd0, 56'h0},
      '{8'h3C, 32'd6,          3'd0, 56'h0},
      '{8'h7F, 32'd7,          3'd4, 56'h05903C7F000000},
      '{8'h80, 32'd5,          3'd0, 56'h0},
      '{8'h00, 32'd5,          3'd0, 56'h0},
      '{8'h00, 32'd5,          3'd4, 56'h00800000000000},
      '{8'hBF, 32'h1000_0004,  3'd0, 56'h0},
      '{8'hFF, 32'd0,          3'd0, 56'h0},
      '{8'hF0, 32'd0,          3'd7, 56'hFFFFFF7FB0FFF0},
      '{8'h9A, 32'hFFFF_FFFF,  3'd0, 56'h0},
      '{8'h40, 32'd0,          3'd0, 56'h0},
      '{8'h40, 32'd0,          3'd7, 56'hFFFFFF7F904040},
      '{8'h85, 32'd0,          3'd0, 56'h0},
      '{8'h11, 32'd0,          3'd0, 56'h0},
      '{8'h22, 32'd0,          3'd4, 56'h00801122000000},
      '{8'h45, 32'd500,        3'd0, 56'h0},
      '{8'hC3, 32'd100,        3'd0, 56'h0},
      '{8'h90, 32'd0,          3'd0, 56'h0},
      '{8'hF0, 32'd200,        3'd0, 56'h0},
      '{8'hB0, 32'd0,          3'd0, 56'h0},
      '{8'hA0, 32'd300,        3'd0, 56'h0},
      '{8'hE7, 32'd301,        3'd0, 56'h0},
      '{8'hF8, 32'd302,        3'd0, 56'h0},
      '{8'h90, 32'h0000_4000,  3'd0, 56'h0},
      '{8'h01, 32'd0,          3'd0, 56'h0},
      '{8'h7E, 32'd0,          3'd6, 56'h81800090017E00}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_request = 1'b0;

   msse_req_if req_ch ();
   msse_rsp_if rsp_ch ();

   midi_stream_to_smf_event_encoder_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   phase_type            enc_phase      = PH_IDLE;
   kind_type             enc_kind       = KIND_NOTE_OFF;
   logic [7:0]           enc_first      = 8'h00;
   logic [TIME_BITS-1:0] enc_event_time = '0;
   logic [TIME_BITS-1:0] enc_prev_time  = '0;
   logic [7:0]           enc_bytes [7];
   track_entry_type      track_due [$];
   int                   fail_count     = 0;
   int                   burst_left     = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int encode_midi(input logic [7:0] b, input logic [TIME_BITS-1:0] t);
      logic [DIFF_BITS-1:0]  diff;
      logic [DELTA_BITS-1:0] delta;
      logic [6:0]            grp;
      logic                  started;
      int                    n;
      n = 0;
      case (enc_phase)
         PH_DATA1: begin
            enc_first = b;
            enc_phase = PH_DATA2;
         end
         PH_DATA2: begin
            enc_phase = PH_IDLE;
            diff = '0;
            if (enc_event_time >= enc_prev_time) begin
               diff = DIFF_BITS'(enc_event_time - enc_prev_time);
            end
            delta = (diff > DELTA_MAX) ? DELTA_MAX[DELTA_BITS-1:0] : diff[DELTA_BITS-1:0];
            started = 1'b0;
            // every group from the highest nonzero one down, zero middle groups kept
            for (int g = 3; g > 0; g--) begin
               grp = delta[7*g +: 7];
               if (grp != 7'd0 || started) begin
                  started = 1'b1;
                  enc_bytes[n] = {1'b1, grp};
                  n++;
               end
            end
            enc_bytes[n] = {1'b0, delta[6:0]};
            n++;
            case (enc_kind)
               KIND_NOTE_OFF: enc_bytes[n] = STATUS_NOTE_OFF;
               KIND_NOTE_ON:  enc_bytes[n] = STATUS_NOTE_ON;
               default:       enc_bytes[n] = STATUS_CONTROL;
            endcase
            enc_bytes[n+1] = enc_first;
            enc_bytes[n+2] = b;
            n += 3;
            enc_prev_time = enc_event_time;
         end
         PH_SKIP: begin
            enc_phase = PH_IDLE;
         end
         default: begin
            enc_phase = PH_IDLE;
            if (b[7]) begin
               enc_event_time = t;
               case (b[7:4])
                  NIB_NOTE_OFF: begin
                     enc_kind  = KIND_NOTE_OFF;
                     enc_phase = PH_DATA1;
                  end
                  NIB_NOTE_ON: begin
                     enc_kind  = KIND_NOTE_ON;
                     enc_phase = PH_DATA1;
                  end
                  NIB_CONTROL: begin
                     enc_kind  = KIND_CONTROL;
                     enc_phase = PH_DATA1;
                  end
                  NIB_PROGRAM: enc_phase = PH_SKIP;
                  NIB_SYSTEM: begin
                     if (b == SYSEX_START) enc_phase = PH_SKIP;
                  end
                  default: ;
               endcase
            end
         end
      endcase
      return n;
   endfunction

   function automatic logic [7:0] pick_data_byte();
      // now and then a byte with bit 7 set lands where data is due
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   task automatic send_midi(input logic [7:0] b, input logic [TIME_BITS-1:0] t,
                            input logic [2:0] n_typed, input logic [0:6][7:0] typed);
      int n;
      req_ch.valid     <= 1'b1;
      req_ch.midi_byte <= b;
      req_ch.time_ms   <= t;
      do @(posedge clock); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      n = encode_midi(b, t);
      if (n_typed != 3'd0) n = n_typed;
      for (int k = 0; k < n; k++) begin
         track_due.push_back('{(n_typed != 3'd0) ? typed[k] : enc_bytes[k], k == n - 1});
      end
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
   endtask

   initial begin
      int                   sent;
      int                   pick;
      int                   held;
      int                   drained;
      logic [7:0]           status;
      logic [TIME_BITS-1:0] now_ms;
      req_ch.valid     = 1'b0;
      req_ch.midi_byte = 8'h00;
      req_ch.time_ms   = '0;
      sent    = 0;
      held    = 0;
      drained = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIR_TABLE); i++) begin
         send_midi(DIR_TABLE[i].midi, DIR_TABLE[i].stamp, DIR_TABLE[i].n_typed,
                   DIR_TABLE[i].typed);
         pace();
      end

      now_ms = 32'h0000_4000;
      while (sent < RANDOM_ITEMS) begin
         if (held == 0 && sent >= 100) begin
            held = 1;
            hold_request <= 1'b1;
         end
         if (drained == 0 && sent >= 220) begin
            drained = 1;
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (track_due.size() != 0);
         end

         case ($urandom_range(0, 15))
            0:       now_ms = $urandom();
            1:       now_ms = now_ms - $urandom_range(1, 5000);
            2:       now_ms = now_ms + $urandom_range(16384, 1 << 22);
            3:       now_ms = now_ms + $urandom_range(1 << 22, 1 << 29);
            4, 5, 6: now_ms = now_ms + $urandom_range(128, 16383);
            default: now_ms = now_ms + $urandom_range(0, 127);
         endcase

         pick = $urandom_range(0, 19);
         if (pick < 12 || pick >= 18) begin
            case ($urandom_range(0, 2))
               0:       status = {NIB_NOTE_OFF, 4'($urandom_range(0, 15))};
               1:       status = {NIB_NOTE_ON, 4'($urandom_range(0, 15))};
               default: status = {NIB_CONTROL, 4'($urandom_range(0, 15))};
            endcase
            send_midi(status, now_ms, 3'd0, '0);
            pace();
            send_midi(pick_data_byte(), $urandom(), 3'd0, '0);
            pace();
            sent += 2;
            // without this byte the message is truncated and the next status byte is taken as data
            if (pick < 12) begin
               send_midi(pick_data_byte(), $urandom(), 3'd0, '0);
               pace();
               sent++;
            end
         end else if (pick < 14) begin
            send_midi({NIB_PROGRAM, 4'($urandom_range(0, 15))}, now_ms, 3'd0, '0);
            pace();
            send_midi(pick_data_byte(), $urandom(), 3'd0, '0);
            pace();
            sent += 2;
         end else if (pick == 14) begin
            send_midi(SYSEX_START, now_ms, 3'd0, '0);
            pace();
            send_midi(pick_data_byte(), $urandom(), 3'd0, '0);
            pace();
            sent += 2;
         end else if (pick == 15) begin
            case ($urandom_range(0, 3))
               0:       status = {NIB_POLY_PRESSURE, 4'($urandom_range(0, 15))};
               1:       status = {NIB_CHAN_PRESSURE, 4'($urandom_range(0, 15))};
               2:       status = {NIB_PITCH_BEND, 4'($urandom_range(0, 15))};
               default: status = SYSEX_START + 8'($urandom_range(1, 15));
            endcase
            send_midi(status, now_ms, 3'd0, '0);
            pace();
            sent++;
         end else if (pick == 16) begin
            send_midi(8'($urandom_range(0, 255)), now_ms, 3'd0, '0);
            pace();
            sent++;
         end else begin
            // stray data byte, not counted toward RANDOM_ITEMS
            send_midi(8'($urandom_range(0, 127)), $urandom(), 3'd0, '0);
            pace();
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (track_due.size() != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      int mode;
      int mode_left;
      int tick;
      rsp_ch.ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // long hold-off so the block backs up into its input
            hold_request <= 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         tick++;
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= (tick % 5) != 2 && (tick % 7) != 4;
            default: rsp_ch.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      track_entry_type due;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (track_due.size() == 0) begin
            $error("track_byte: none expected, actual %h", rsp_ch.track_byte);
            fail_count++;
         end else begin
            due = track_due.pop_front();
            if (rsp_ch.track_byte !== due.track_byte) begin
               $error("track_byte: expected %h, actual %h", due.track_byte, rsp_ch.track_byte);
               fail_count++;
            end
            if (rsp_ch.last_of_event !== due.last_of_event) begin
               $error("last_of_event: expected %b, actual %b", due.last_of_event,
                      rsp_ch.last_of_event);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
